[src/hci_h4_rx_deframer_macros.svh]
// Assertion macros for the HCI H4 receive deframer checker.
// Each macro expands to one labeled concurrent assertion clocked on clk.
`ifndef HCI_H4_RX_DEFRAMER_MACROS_SVH
`define HCI_H4_RX_DEFRAMER_MACROS_SVH

// Same-cycle implication, ignored while rst is high
`define H4RX_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while rst is high
`define H4RX_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication, checked through reset as well
`define H4RX_ASSERT_NXT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/h4rx_pkg.sv]
// ---------------------------------------------------------------------------
// h4rx_pkg
// Shared types and constants of the HCI H4 receive deframer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package h4rx_pkg;

  // H4 packet type bytes
  localparam logic [7:0] TYPE_EVENT = 8'h04;
  localparam logic [7:0] TYPE_ACL   = 8'h02;

  // Packet kind tags
  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_ACL   = 1'b1;

  // Default depth of the queue between parser and output stage
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // One deframed byte with its tags
  typedef struct packed {
    logic       last;
    logic       first;
    logic       kind;
    logic [7:0] data;
  } pkt_item_t;

  // Queue status seen by the parser and the output stage
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[src/h4rx_front.sv]
// ---------------------------------------------------------------------------
// h4rx_front
// Byte parser: tracks the H4 framing phase and tags every packet byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module h4rx_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,
  input  h4rx_pkg::q_status_t q_status,
  output logic               push,
  output h4rx_pkg::pkt_item_t push_item
);
  import h4rx_pkg::*;

  // Framing phases
  localparam logic [3:0] PH_TYPE      = 4'd0;
  localparam logic [3:0] PH_EVT_CODE  = 4'd1;
  localparam logic [3:0] PH_EVT_LEN   = 4'd2;
  localparam logic [3:0] PH_EVT_PARAM = 4'd3;
  localparam logic [3:0] PH_ACL_H0    = 4'd4;
  localparam logic [3:0] PH_ACL_H1    = 4'd5;
  localparam logic [3:0] PH_ACL_L0    = 4'd6;
  localparam logic [3:0] PH_ACL_L1    = 4'd7;
  localparam logic [3:0] PH_ACL_DATA  = 4'd8;

  logic [3:0]  phase, phase_next;
  logic [15:0] remaining, remaining_next;  // payload bytes still to come
  logic [7:0]  len_lo, len_lo_next;        // low ACL length byte
  logic        accept;
  logic        emit;
  logic        kind, first, last;

  assign s_axis_tready = !q_status.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Phase decode and tagging
  always_comb begin
    phase_next     = phase;
    remaining_next = remaining;
    len_lo_next    = len_lo;
    emit           = 1'b1;
    kind           = KIND_EVENT;
    first          = 1'b0;
    last           = 1'b0;
    unique case (phase)
      PH_EVT_CODE: begin
        first      = 1'b1;
        phase_next = PH_EVT_LEN;
      end
      PH_EVT_LEN: begin
        remaining_next = {8'h00, s_axis_tdata};
        last           = (s_axis_tdata == 8'h00);
        phase_next     = last ? PH_TYPE : PH_EVT_PARAM;
      end
      PH_EVT_PARAM: begin
        remaining_next = remaining - 16'd1;
        last           = (remaining == 16'd1);
        phase_next     = last ? PH_TYPE : PH_EVT_PARAM;
      end
      PH_ACL_H0: begin
        kind       = KIND_ACL;
        first      = 1'b1;
        phase_next = PH_ACL_H1;
      end
      PH_ACL_H1: begin
        kind       = KIND_ACL;
        phase_next = PH_ACL_L0;
      end
      PH_ACL_L0: begin
        kind        = KIND_ACL;
        len_lo_next = s_axis_tdata;
        phase_next  = PH_ACL_L1;
      end
      PH_ACL_L1: begin
        kind           = KIND_ACL;
        remaining_next = {s_axis_tdata, len_lo};
        last           = (s_axis_tdata == 8'h00) && (len_lo == 8'h00);
        phase_next     = last ? PH_TYPE : PH_ACL_DATA;
      end
      PH_ACL_DATA: begin
        kind           = KIND_ACL;
        remaining_next = remaining - 16'd1;
        last           = (remaining == 16'd1);
        phase_next     = last ? PH_TYPE : PH_ACL_DATA;
      end
      default: begin
        // waiting for a type byte; unknown types are dropped
        emit = 1'b0;
        if (s_axis_tdata == TYPE_EVENT) begin
          phase_next = PH_EVT_CODE;
        end else if (s_axis_tdata == TYPE_ACL) begin
          phase_next = PH_ACL_H0;
        end else begin
          phase_next = PH_TYPE;
        end
      end
    endcase
  end

  assign push            = accept && emit;
  assign push_item.data  = s_axis_tdata;
  assign push_item.kind  = kind;
  assign push_item.first = first;
  assign push_item.last  = last;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TYPE;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  // Length tracking
  always_ff @(posedge clk) begin
    if (accept) begin
      remaining <= remaining_next;
      len_lo    <= len_lo_next;
    end
  end

endmodule

[src/h4rx_queue.sv]
// ---------------------------------------------------------------------------
// h4rx_queue
// Small FIFO of tagged bytes between the parser and the output stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module h4rx_queue #(
  parameter int DEPTH = h4rx_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  h4rx_pkg::pkt_item_t push_item,
  input  logic                pop,
  output h4rx_pkg::pkt_item_t pop_item,
  output h4rx_pkg::q_status_t q_status
);
  import h4rx_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
  localparam logic [PW-1:0] LAST_PTR   = PW'(DEPTH - 1);

  pkt_item_t     mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign q_status.full  = (count == FULL_COUNT);
  assign q_status.empty = (count == '0);
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign pop_item       = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[src/h4rx_back.sv]
// ---------------------------------------------------------------------------
// h4rx_back
// Output register: drains the queue onto the master stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module h4rx_back (
  input  logic                clk,
  input  logic                rst,
  input  h4rx_pkg::q_status_t q_status,
  input  h4rx_pkg::pkt_item_t pop_item,
  output logic                pop,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,
  output logic [1:0]          m_axis_tuser,
  output logic                m_axis_tlast
);
  import h4rx_pkg::*;

  pkt_item_t out_item;

  // Load when the register is free or its transaction completes
  assign pop = !q_status.empty && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= !q_status.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item <= pop_item;
    end
  end

  assign m_axis_tdata = out_item.data;
  assign m_axis_tuser = {out_item.first, out_item.kind};
  assign m_axis_tlast = out_item.last;

endmodule

[src/hci_h4_rx_deframer.sv]
// ---------------------------------------------------------------------------
// hci_h4_rx_deframer
// Splits an HCI H4 UART byte stream into tagged event and ACL packet bytes.
//
//   channel   dir  content
//   s_axis    in   tdata[7:0] rx_byte
//   m_axis    out  tdata[7:0] pkt_byte, tuser[0] pkt_kind,
//                  tuser[1] first_of_packet, tlast last_of_packet
//
// One byte is accepted per cycle while the queue has room; a packet byte
// passes from the parser through the queue and the output register to m_axis.
// The parser keeps taking bytes while the queue has room, so a stalled
// output fills the queue of QUEUE_DEPTH entries before s_axis_tready drops.
// Type bytes produce no output transaction. Reset is synchronous and returns
// the parser to waiting for a type byte and empties the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hci_h4_rx_deframer #(
  parameter int QUEUE_DEPTH = h4rx_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] pkt_byte
  output logic [1:0] m_axis_tuser,   // [0] pkt_kind, [1] first_of_packet
  output logic       m_axis_tlast
);
  import h4rx_pkg::*;

  q_status_t q_status;
  pkt_item_t push_item, pop_item;
  logic      push, pop;

  h4rx_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_status      (q_status),
    .push          (push),
    .push_item     (push_item)
  );

  h4rx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_status  (q_status)
  );

  h4rx_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_status      (q_status),
    .pop_item      (pop_item),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

[src/h4rx_checker.sv]
// ---------------------------------------------------------------------------
// h4rx_checker
// Port-level checks of the HCI H4 receive deframer, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hci_h4_rx_deframer_macros.svh"

module h4rx_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // Stalled output transaction keeps its valid
  `H4RX_ASSERT_NXT(a_out_valid_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "m_axis_tvalid dropped under stall")

  // Stalled output transaction keeps its payload
  `H4RX_ASSERT_NXT(a_out_data_hold, m_axis_tvalid && !m_axis_tready, $stable({m_axis_tdata, m_axis_tuser, m_axis_tlast}), "m_axis payload changed under stall")

  // Reset leaves no output transaction pending
  `H4RX_ASSERT_NXT_RST(a_reset_clears, rst, !m_axis_tvalid, "output valid after reset")

  // Every packet has at least one header byte after its first one
  `H4RX_ASSERT_IMP(a_first_not_last, m_axis_tvalid && m_axis_tuser[1], !m_axis_tlast, "first byte marked last")

endmodule

bind hci_h4_rx_deframer h4rx_checker u_h4rx_checker (.*);

[test/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// Testbench for the HCI H4 receive deframer. A byte stream of event and ACL
// packets, with stray type bytes mixed in, is fed on s_axis. The scoreboard
// tracks the deframing state itself, predicts every tagged packet byte and
// compares each m_axis transaction field by field, in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import h4rx_pkg::*;

  // Deframing phases tracked by the scoreboard
  typedef enum logic [3:0] {
    PH_TYPE,
    PH_EVT_CODE,
    PH_EVT_LEN,
    PH_EVT_PARAM,
    PH_ACL_H0,
    PH_ACL_H1,
    PH_ACL_L0,
    PH_ACL_L1,
    PH_ACL_DATA
  } h4_phase_e;

  // Tracks the H4 framing and holds the packet bytes still to come
  class h4_packet_scoreboard;
    h4_phase_e   phase;
    logic [7:0]  evt_len;
    logic [7:0]  evt_pos;
    logic [15:0] acl_len;
    logic [15:0] acl_pos;
    pkt_item_t   expected_pkt_bytes[$];
    int          errors;
    int          bytes_predicted;
    int          bytes_sent;

    function new();
      phase = PH_TYPE;
      evt_len = '0;
      evt_pos = '0;
      acl_len = '0;
      acl_pos = '0;
      errors = 0;
      bytes_predicted = 0;
      bytes_sent = 0;
    endfunction

    // One accepted rx byte: advance the framing, queue the tagged byte if any
    function void take_rx_byte(logic [7:0] b);
      pkt_item_t item;
      bit        passes;
      passes = 1'b1;
      bytes_sent++;
      item.data = b;
      item.kind = KIND_ACL;
      item.first = 1'b0;
      item.last = 1'b0;
      case (phase)
        PH_EVT_CODE: begin
          item.kind = KIND_EVENT;
          item.first = 1'b1;
          phase = PH_EVT_LEN;
        end
        PH_EVT_LEN: begin
          item.kind = KIND_EVENT;
          evt_len = b;
          evt_pos = '0;
          item.last = (b == 8'd0);
          phase = item.last ? PH_TYPE : PH_EVT_PARAM;
        end
        PH_EVT_PARAM: begin
          item.kind = KIND_EVENT;
          evt_pos = evt_pos + 8'd1;
          item.last = (evt_pos >= evt_len);
          if (item.last) phase = PH_TYPE;
        end
        PH_ACL_H0: begin
          item.first = 1'b1;
          phase = PH_ACL_H1;
        end
        PH_ACL_H1: phase = PH_ACL_L0;
        PH_ACL_L0: begin
          acl_len = {8'd0, b};
          phase = PH_ACL_L1;
        end
        PH_ACL_L1: begin
          acl_len[15:8] = b;
          acl_pos = '0;
          item.last = (acl_len == 16'd0);
          phase = item.last ? PH_TYPE : PH_ACL_DATA;
        end
        PH_ACL_DATA: begin
          acl_pos = acl_pos + 16'd1;
          item.last = (acl_pos >= acl_len);
          if (item.last) phase = PH_TYPE;
        end
        default: begin
          // type byte: no packet byte; unknown types leave us waiting
          passes = 1'b0;
          if (b == TYPE_EVENT) phase = PH_EVT_CODE;
          else if (b == TYPE_ACL) phase = PH_ACL_H0;
          else phase = PH_TYPE;
        end
      endcase
      if (passes) begin
        expected_pkt_bytes.push_back(item);
        bytes_predicted++;
      end
    endfunction

    function void report_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h",
                 $time, name, exp_val, act_val);
        errors++;
      end
    endfunction

    // One m_axis transaction against the oldest predicted byte
    function void check_pkt_byte(pkt_item_t got);
      pkt_item_t exp_item;
      if (expected_pkt_bytes.size() == 0) begin
        $display("%0t: unexpected packet byte, expected none, actual %0h",
                 $time, got);
        errors++;
      end else begin
        exp_item = expected_pkt_bytes.pop_front();
        report_field("pkt_byte", exp_item.data, got.data);
        report_field("pkt_kind", exp_item.kind, got.kind);
        report_field("first_of_packet", exp_item.first, got.first);
        report_field("last_of_packet", exp_item.last, got.last);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'd0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic       m_axis_tlast;

  h4_packet_scoreboard sb = new();
  bit quiet = 1'b0;      // no idling on either side
  bit long_hold = 1'b0;  // asks the receiver for one long stall

  hci_h4_rx_deframer dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: check each output transaction, stall in random bursts
  initial begin
    int stall_left;
    pkt_item_t got;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        got.data = m_axis_tdata;
        got.kind = m_axis_tuser[0];
        got.first = m_axis_tuser[1];
        got.last = m_axis_tlast;
        sb.check_pkt_byte(got);
      end
      if (long_hold) begin
        long_hold = 1'b0;
        stall_left = 200;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7);
      end
      if (rst) begin
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one byte until a transaction takes it, with an optional gap first
  task automatic send_byte(logic [7:0] b, bit may_idle = 1'b1);
    int gap;
    if (may_idle && !quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk); while (!s_axis_tready);
    sb.take_rx_byte(b);
  endtask

  task automatic send_event(int len, bit may_idle = 1'b1);
    send_byte(TYPE_EVENT, may_idle);
    send_byte(8'($urandom_range(0, 255)), may_idle);
    send_byte(len[7:0], may_idle);
    repeat (len) send_byte(8'($urandom_range(0, 255)), may_idle);
  endtask

  task automatic send_acl(int len);
    send_byte(TYPE_ACL);
    send_byte(8'($urandom_range(0, 255)));
    send_byte(8'($urandom_range(0, 255)));
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    repeat (len) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Hold off the sender until every predicted byte has been seen
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_pkt_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [7:0] noise;
    int pick;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: unknown type bytes are dropped
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h03);
    // zero-length event ends on its length byte
    send_byte(TYPE_EVENT);
    send_byte(8'hFF);
    send_byte(8'h00);
    // one-parameter event
    send_byte(TYPE_EVENT);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'hFF);
    // zero-length ACL ends on the high length byte
    send_byte(TYPE_ACL);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);
    // one-byte ACL
    send_byte(TYPE_ACL);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'hAA);
    drain();

    // Receiver stalls long while the sender keeps offering a maximal event
    long_hold = 1'b1;
    send_event(255, 1'b0);
    drain();
    // ACL with a nonzero high length byte
    send_acl(300);
    drain();

    // Random packet stream, mostly well formed, some stray bytes
    while (sb.bytes_sent < 1900) begin
      if (sb.bytes_sent > 1650) quiet = 1'b1;
      pick = $urandom_range(0, 19);
      if (pick < 9) begin
        send_event(($urandom_range(0, 15) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(0, 12));
      end else if (pick < 18) begin
        send_acl(($urandom_range(0, 30) == 0) ? $urandom_range(256, 320)
                                              : $urandom_range(0, 12));
      end else begin
        noise = 8'($urandom_range(0, 255));
        send_byte(noise);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.expected_pkt_bytes.size() != 0) begin
      $display("%0t: packet bytes missing, expected %0d more, actual 0",
               $time, sb.expected_pkt_bytes.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/h4rx_pkg.sv
src/h4rx_front.sv
src/h4rx_queue.sv
src/h4rx_back.sv
src/hci_h4_rx_deframer.sv
src/h4rx_checker.sv
test/tb_top.sv
